/* hdl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int SLOTS     = 16;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 64;
   localparam int IDX_BITS  = $clog2(SLOTS);

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int SLOT_BITS   = 4;

   localparam int REQ_TDATA_BITS = ((KEY_BITS + DATA_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((SLOT_BITS + DATA_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_PTR_BITS = 1;
   localparam int FIFO_CNT_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [1:0]           op;
      logic [IDX_BITS-1:0]  home;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] data;
   } cmd_type;

endpackage

/* hdl/linear_probe_hash_table_top.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Sixteen-slot open-addressing table with linear probing.
// ----------------------------------------------------------------------------
// Each request beat gives one response beat. The request stage takes a beat
// per cycle until the two-entry command queue and its own register are full.
// The probe engine then picks up a command, examines the slots in turn from
// home (from 1 up to SLOTS, that is 16) and presents the result, holding it
// while the response is stalled; it takes no new command until the response
// has been accepted. Insert stops at the first empty slot; search and delete
// stop at the first matching key and otherwise walk all slots. Mode three
// answers "not found" without probing. The table is empty after reset.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lookup_key [31:0], record_data [95:32]
   input  logic [lpht_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // mode [1:0]
   input  logic [lpht_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot_index [3:0], found_data [67:4], zero [71:68]
   output logic [lpht_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // status [1:0]
   output logic [lpht_pkg::STATUS_BITS-1:0]    rsp_tuser
);

   logic              push_valid;
   logic              push_ready;
   lpht_pkg::cmd_type push_cmd;
   logic              pop_valid;
   logic              pop_ready;
   lpht_pkg::cmd_type pop_cmd;

   lpht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lpht_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lpht_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hdl/lpht_front.sv */
// ----------------------------------------------------------------------------
// lpht_front
// Request stage: takes a beat, decodes the mode and computes the home slot.
// ----------------------------------------------------------------------------
module lpht_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lpht_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [lpht_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                push_valid,
   input  logic                                push_ready,
   output lpht_pkg::cmd_type                   push_cmd
);

   logic              valid_ff;
   logic              valid_in;
   lpht_pkg::cmd_type cmd_ff;
   lpht_pkg::cmd_type cmd_in;
   lpht_pkg::cmd_type decoded;
   logic              accept;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~valid_ff | push_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      decoded.key  = req_tdata[lpht_pkg::KEY_BITS-1:0];
      decoded.data = req_tdata[lpht_pkg::KEY_BITS +: lpht_pkg::DATA_BITS];
      decoded.home = req_tdata[lpht_pkg::IDX_BITS-1:0];
      unique case (req_tuser)
         lpht_pkg::MODE_INSERT: decoded.op = lpht_pkg::OP_INSERT;
         lpht_pkg::MODE_SEARCH: decoded.op = lpht_pkg::OP_SEARCH;
         lpht_pkg::MODE_DELETE: decoded.op = lpht_pkg::OP_DELETE;
         default:               decoded.op = lpht_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in = 1'b1;
         cmd_in   = decoded;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

/* hdl/lpht_fifo.sv */
// ----------------------------------------------------------------------------
// lpht_fifo
// Short command queue between the request stage and the probe engine.
// ----------------------------------------------------------------------------
module lpht_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lpht_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lpht_pkg::cmd_type pop_cmd
);

   lpht_pkg::cmd_type                      entry_ff [lpht_pkg::FIFO_DEPTH];
   logic [lpht_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_ff;
   logic [lpht_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_in;
   logic [lpht_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_ff;
   logic [lpht_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_in;
   logic [lpht_pkg::FIFO_CNT_BITS-1:0]     count_ff;
   logic [lpht_pkg::FIFO_CNT_BITS-1:0]     count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign push_ready = count_ff != lpht_pkg::FIFO_CNT_BITS'(lpht_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/lpht_engine.sv */
// ----------------------------------------------------------------------------
// lpht_engine
// Probe engine: walks the slots one per cycle from home and holds the result.
// ----------------------------------------------------------------------------
module lpht_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  lpht_pkg::cmd_type                   pop_cmd,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lpht_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic [lpht_pkg::STATUS_BITS-1:0]    rsp_tuser
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_RESP  = 2'd2;

   logic [1:0]                          state_ff;
   logic [1:0]                          state_in;
   lpht_pkg::cmd_type                   cmd_ff;
   lpht_pkg::cmd_type                   cmd_in;
   logic [lpht_pkg::IDX_BITS-1:0]       pos_ff;
   logic [lpht_pkg::IDX_BITS-1:0]       pos_in;
   logic [lpht_pkg::IDX_BITS-1:0]       pos_next;
   logic [lpht_pkg::IDX_BITS-1:0]       cnt_ff;
   logic [lpht_pkg::IDX_BITS-1:0]       cnt_in;
   logic [lpht_pkg::STATUS_BITS-1:0]    status_ff;
   logic [lpht_pkg::STATUS_BITS-1:0]    status_in;
   logic [lpht_pkg::SLOT_BITS-1:0]      slot_ff;
   logic [lpht_pkg::SLOT_BITS-1:0]      slot_in;
   logic [lpht_pkg::DATA_BITS-1:0]      found_ff;
   logic [lpht_pkg::DATA_BITS-1:0]      found_in;

   logic [lpht_pkg::SLOTS-1:0]          slot_valid_ff;
   logic [lpht_pkg::KEY_BITS-1:0]       slot_key_ff  [lpht_pkg::SLOTS];
   logic [lpht_pkg::DATA_BITS-1:0]      slot_data_ff [lpht_pkg::SLOTS];

   logic                                probing;
   logic                                hit_insert;
   logic                                hit_find;
   logic                                last_probe;

   assign probing    = state_ff == ST_PROBE;
   assign hit_insert = probing & (cmd_ff.op == lpht_pkg::OP_INSERT) & ~slot_valid_ff[pos_ff];
   assign hit_find   = probing & ((cmd_ff.op == lpht_pkg::OP_SEARCH) ||
                                  (cmd_ff.op == lpht_pkg::OP_DELETE)) &
                       slot_valid_ff[pos_ff] & (slot_key_ff[pos_ff] == cmd_ff.key);
   assign last_probe = cnt_ff == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1);
   assign pos_next   = (pos_ff == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1)) ?
                       '0 : pos_ff + 1'b1;

   assign pop_ready  = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_RESP;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(lpht_pkg::RSP_TDATA_BITS - lpht_pkg::SLOT_BITS
                          - lpht_pkg::DATA_BITS){1'b0}}, found_ff, slot_ff};

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cmd_in    = pop_cmd;
               pos_in    = pop_cmd.home;
               cnt_in    = '0;
               status_in = lpht_pkg::STATUS_ABSENT;
               slot_in   = '0;
               found_in  = '0;
               state_in  = (pop_cmd.op == lpht_pkg::OP_NOP) ? ST_RESP : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (hit_insert) begin
               status_in = lpht_pkg::STATUS_OK;
               slot_in   = lpht_pkg::SLOT_BITS'(pos_ff);
               found_in  = '0;
               state_in  = ST_RESP;
            end else if (hit_find) begin
               status_in = lpht_pkg::STATUS_OK;
               slot_in   = lpht_pkg::SLOT_BITS'(pos_ff);
               found_in  = slot_data_ff[pos_ff];
               state_in  = ST_RESP;
            end else if (last_probe) begin
               status_in = (cmd_ff.op == lpht_pkg::OP_INSERT) ?
                           lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_ABSENT;
               slot_in   = '0;
               found_in  = '0;
               state_in  = ST_RESP;
            end else begin
               pos_in = pos_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (hit_insert) begin
            slot_valid_ff[pos_ff] <= 1'b1;
         end else if (hit_find && (cmd_ff.op == lpht_pkg::OP_DELETE)) begin
            slot_valid_ff[pos_ff] <= 1'b0;
         end
      end
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      found_ff  <= found_in;
      if (hit_insert) begin
         slot_key_ff[pos_ff]  <= cmd_ff.key;
         slot_data_ff[pos_ff] <= cmd_ff.data;
      end
   end

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status_ff != lpht_pkg::STATUS_OK)) |->
      (slot_ff == '0 && found_ff == '0))
      else $error("error result carries a slot or payload");

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      hit_insert |=> slot_valid_ff[$past(pos_ff)])
      else $error("inserted slot not marked valid");

   a_no_double_hit: assert property (@(posedge clock) disable iff (reset)
      !(hit_insert && hit_find))
      else $error("insert and lookup hit in the same probe");

   a_resp_after_probe: assert property (@(posedge clock) disable iff (reset)
      (probing && (hit_insert || hit_find || last_probe)) |=> rsp_tvalid)
      else $error("probe end without a result");

endmodule
